// ===== rtl/dlle_pkg.sv =====
// Shared types and constants for the doubly linked list engine.
// No dependencies; used by dlle_ctrl, dlle_dpath and the top level.
package dlle_pkg;

	// Node count (power of two) and derived widths
	localparam int NODES  = 1024;
	localparam int NODE_W = $clog2(NODES);
	localparam int LINK_W = NODE_W + 1;

	// Link value that marks "none" / end of list
	localparam logic [LINK_W-1:0] END_LINK    = LINK_W'(NODES);
	localparam logic [LINK_W-1:0] NEXT_ID_RST = LINK_W'(2);

	// Stream widths: fields padded to whole bytes
	localparam int IN_W        = 2 + NODE_W + 1;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int RES_W       = 2 + NODE_W + 2 * LINK_W + 1;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_BAD    = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REMOVED = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT0,
		S_INIT1,
		S_IDLE,
		S_CHECK,
		S_ANCHOR,
		S_UNLINK,
		S_LINK1,
		S_LINK2,
		S_DONE
	} state_t;

	// Controller -> datapath strobes
	typedef struct packed {
		logic accept;
		logic check;
		logic anchor_ld;
		logic init0;
		logic init1;
		logic unlink;
		logic link1;
		logic link2;
		logic out_ld;
	} dp_ctl_t;

	// Datapath -> controller status
	typedef struct packed {
		cmd_code_t cmd;
		logic      side;
		status_t   chk;
	} dp_stat_t;

	// One result item, status in the low bits
	typedef struct packed {
		logic              is_removed;
		logic [LINK_W-1:0] right_link;
		logic [LINK_W-1:0] left_link;
		logic [NODE_W-1:0] new_node;
		status_t           status;
	} result_t;

endpackage

// ===== rtl/dlle_ctrl.sv =====
// Command sequencer for the doubly linked list engine.
// Depends on dlle_pkg; drives dlle_dpath through dp_ctl_t strobes.
module dlle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  dlle_pkg::dp_stat_t stat,
	output dlle_pkg::dp_ctl_t  ctl
);

	dlle_pkg::state_t state_q, state_nxt;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == dlle_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dlle_pkg::S_INIT0: state_nxt = dlle_pkg::S_INIT1;
			dlle_pkg::S_INIT1: state_nxt = dlle_pkg::S_IDLE;
			dlle_pkg::S_IDLE: begin
				if (in_valid) state_nxt = dlle_pkg::S_CHECK;
			end
			dlle_pkg::S_CHECK: begin
				if (stat.chk != dlle_pkg::ST_OK) begin
					state_nxt = dlle_pkg::S_DONE;
				end else begin
					case (stat.cmd)
						dlle_pkg::CMD_INSERT:
							state_nxt = stat.side ? dlle_pkg::S_LINK1 : dlle_pkg::S_ANCHOR;
						dlle_pkg::CMD_REMOVE: state_nxt = dlle_pkg::S_UNLINK;
						default:              state_nxt = dlle_pkg::S_DONE;
					endcase
				end
			end
			dlle_pkg::S_ANCHOR: state_nxt = dlle_pkg::S_LINK1;
			dlle_pkg::S_UNLINK: state_nxt = dlle_pkg::S_DONE;
			dlle_pkg::S_LINK1:  state_nxt = dlle_pkg::S_LINK2;
			dlle_pkg::S_LINK2:  state_nxt = dlle_pkg::S_DONE;
			dlle_pkg::S_DONE: begin
				if (out_free) state_nxt = dlle_pkg::S_IDLE;
			end
			default: state_nxt = dlle_pkg::S_INIT0;
		endcase
	end

	// Datapath strobes
	always_comb begin
		ctl = '0;
		unique case (state_q)
			dlle_pkg::S_INIT0:  ctl.init0 = 1'b1;
			dlle_pkg::S_INIT1:  ctl.init1 = 1'b1;
			dlle_pkg::S_IDLE:   ctl.accept = in_valid;
			dlle_pkg::S_CHECK:  ctl.check = 1'b1;
			dlle_pkg::S_ANCHOR: ctl.anchor_ld = 1'b1;
			dlle_pkg::S_UNLINK: ctl.unlink = 1'b1;
			dlle_pkg::S_LINK1:  ctl.link1 = 1'b1;
			dlle_pkg::S_LINK2:  ctl.link2 = 1'b1;
			dlle_pkg::S_DONE:   ctl.out_ld = out_free;
			default:            ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlle_pkg::S_INIT0;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set on load, cleared when the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/dlle_dpath.sv =====
// Datapath: left/right link memories, removed flags, id counter, result regs.
// Depends on dlle_pkg; sequenced by dlle_ctrl.
module dlle_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dlle_pkg::dp_ctl_t           ctl,
	input  dlle_pkg::cmd_code_t         in_cmd,
	input  logic [dlle_pkg::NODE_W-1:0] in_node,
	input  logic                        in_side,
	output dlle_pkg::dp_stat_t          stat,
	output dlle_pkg::result_t           res_out
);

	localparam int NW = dlle_pkg::NODE_W;
	localparam int LW = dlle_pkg::LINK_W;

	// Link and flag memories
	logic [LW-1:0] left_mem  [dlle_pkg::NODES];
	logic [LW-1:0] right_mem [dlle_pkg::NODES];
	logic          flag_mem  [dlle_pkg::NODES];

	logic [NW-1:0] raddr;
	logic [LW-1:0] l_rd_q, r_rd_q;
	logic          f_rd_q;

	logic          l_we, r_we, f_we;
	logic [NW-1:0] l_wa, r_wa, f_wa;
	logic [LW-1:0] l_wd, r_wd;
	logic          f_wd;

	// Command registers and working links
	dlle_pkg::cmd_code_t cmd_q;
	logic [NW-1:0]       node_q;
	logic                side_q;
	logic [LW-1:0]       a_q, b_q;  // anchor / next, or left / right of target
	logic [LW-1:0]       next_id_q;
	logic [NW-1:0]       new_id;

	dlle_pkg::status_t chk;
	dlle_pkg::result_t res_q, out_q;
	logic              show_links;

	assign new_id = next_id_q[NW-1:0];

	// Read address: incoming node on accept, anchor from left link during check, else the held node
	always_comb begin
		if (ctl.accept) begin
			raddr = in_node;
		end else if (ctl.check) begin
			raddr = l_rd_q[NW-1:0];
		end else begin
			raddr = node_q;
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) left_mem[l_wa] <= l_wd;
		l_rd_q <= left_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (r_we) right_mem[r_wa] <= r_wd;
		r_rd_q <= right_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we) flag_mem[f_wa] <= f_wd;
		f_rd_q <= flag_mem[raddr];
	end

	// Write port selection per step
	always_comb begin
		l_we = 1'b0; l_wa = '0; l_wd = '0;
		r_we = 1'b0; r_wa = '0; r_wd = '0;
		f_we = 1'b0; f_wa = '0; f_wd = 1'b0;
		if (ctl.init0) begin
			// head -> node 1, node 1 left is head, head not removed
			r_we = 1'b1; r_wa = NW'(0); r_wd = LW'(1);
			l_we = 1'b1; l_wa = NW'(1); l_wd = LW'(0);
			f_we = 1'b1; f_wa = NW'(0); f_wd = 1'b0;
		end else if (ctl.init1) begin
			r_we = 1'b1; r_wa = NW'(1); r_wd = dlle_pkg::END_LINK;
			f_we = 1'b1; f_wa = NW'(1); f_wd = 1'b0;
		end else if (ctl.unlink) begin
			f_we = 1'b1; f_wa = node_q; f_wd = 1'b1;
			r_we = (a_q < dlle_pkg::END_LINK); r_wa = a_q[NW-1:0]; r_wd = b_q;
			l_we = (b_q < dlle_pkg::END_LINK); l_wa = b_q[NW-1:0]; l_wd = a_q;
		end else if (ctl.link1) begin
			r_we = 1'b1; r_wa = new_id; r_wd = b_q;
			l_we = 1'b1; l_wa = new_id; l_wd = a_q;
			f_we = 1'b1; f_wa = new_id; f_wd = 1'b0;
		end else if (ctl.link2) begin
			// back-link skipped at the tail
			r_we = 1'b1; r_wa = a_q[NW-1:0]; r_wd = next_id_q;
			l_we = (b_q < dlle_pkg::END_LINK); l_wa = b_q[NW-1:0]; l_wd = next_id_q;
		end
	end

	// Command checks on the read data
	always_comb begin
		chk = dlle_pkg::ST_OK;
		if (cmd_q == dlle_pkg::CMD_BAD || {1'b0, node_q} >= next_id_q) begin
			chk = dlle_pkg::ST_INVALID;
		end else begin
			case (cmd_q)
				dlle_pkg::CMD_INSERT: begin
					if (next_id_q >= dlle_pkg::END_LINK) begin
						chk = dlle_pkg::ST_FULL;
					end else if (f_rd_q) begin
						chk = dlle_pkg::ST_REMOVED;
					end else if (!side_q && (node_q == '0 || l_rd_q >= dlle_pkg::END_LINK)) begin
						chk = dlle_pkg::ST_INVALID;
					end
				end
				dlle_pkg::CMD_REMOVE: begin
					if (node_q == '0) begin
						chk = dlle_pkg::ST_INVALID;
					end else if (f_rd_q) begin
						chk = dlle_pkg::ST_REMOVED;
					end
				end
				default: chk = dlle_pkg::ST_OK;
			endcase
		end
	end

	assign stat.cmd  = cmd_q;
	assign stat.side = side_q;
	assign stat.chk  = chk;

	assign show_links = (chk == dlle_pkg::ST_OK) && (cmd_q == dlle_pkg::CMD_QUERY);

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= in_cmd;
			node_q <= in_node;
			side_q <= in_side;
		end
		if (ctl.check) begin
			a_q <= (cmd_q == dlle_pkg::CMD_INSERT && side_q) ? {1'b0, node_q} : l_rd_q;
			b_q <= r_rd_q;
			res_q.status     <= chk;
			res_q.new_node   <= '0;
			res_q.left_link  <= show_links ?
				((node_q == '0) ? dlle_pkg::END_LINK : l_rd_q) : '0;
			res_q.right_link <= show_links ? r_rd_q : '0;
			res_q.is_removed <= show_links & f_rd_q;
		end
		if (ctl.anchor_ld) begin
			b_q <= r_rd_q;
		end
		if (ctl.link2) begin
			res_q.new_node <= new_id;
		end
		if (ctl.out_ld) begin
			out_q <= res_q;
		end
	end

	// Next free id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= dlle_pkg::NEXT_ID_RST;
		end else if (ctl.link2) begin
			next_id_q <= next_id_q + LW'(1);
		end
	end

	assign res_out = out_q;

endmodule

// ===== rtl/doubly_linked_list_engine_unit.sv =====
// Top level of the doubly linked list engine: stream ports, packing, checks.
// Depends on dlle_pkg, dlle_ctrl and dlle_dpath.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  s_tdata: cmd, node, side
//  m_*      out  m_tvalid/m_tready  m_tdata: status, new_node, left_link, right_link, is_removed
//
// Steps per command: query or rejected: check, done; remove adds unlink; insert
// right adds link1, link2; insert left adds anchor before them; set by the one read port
// of each link memory and the registered read (insert left reads twice, inserts write twice).
// After reset the init states S_INIT0 and S_INIT1 write the head and node 1 links;
// s_tready stays low during it.
// A finished result waits in the output register; the next command is taken meanwhile
// but its result holds in the datapath until m_tready frees the register.
module doubly_linked_list_engine_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [1:0] cmd, [11:2] node, [12] side, rest zero
	input  logic [dlle_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] status, [11:2] new_node, [22:12] left_link, [33:23] right_link,
	// [34] is_removed, rest zero
	output logic [dlle_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int NW = dlle_pkg::NODE_W;

	dlle_pkg::dp_ctl_t  ctl;
	dlle_pkg::dp_stat_t stat;
	dlle_pkg::result_t  res;

	dlle_pkg::cmd_code_t in_cmd;
	logic [NW-1:0]       in_node;
	logic                in_side;

	// Unpack input fields
	assign in_cmd  = dlle_pkg::cmd_code_t'(s_tdata[1:0]);
	assign in_node = s_tdata[NW+1:2];
	assign in_side = s_tdata[NW+2];

	dlle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	dlle_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.in_cmd  (in_cmd),
		.in_node (in_node),
		.in_side (in_side),
		.stat    (stat),
		.res_out (res)
	);

	// Pack result, zero fill
	assign m_tdata = {{(dlle_pkg::OUT_TDATA_W - dlle_pkg::RES_W){1'b0}}, res};

`ifndef SYNTHESIS
	// An accepted command closes the input and is checked next cycle
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && ctl.check))
		else $error("accepted command not followed by check");

	// At most one datapath step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.accept, ctl.check, ctl.anchor_ld, ctl.init0, ctl.init1,
			ctl.unlink, ctl.link1, ctl.link2, ctl.out_ld}))
		else $error("more than one datapath step");

	// A result load always presents a result next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |=> m_tvalid)
		else $error("result load without valid output");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for doubly_linked_list_engine_unit: directed and random list commands,
// checked against an in-bench list predictor. Depends on dlle_pkg and the RTL top level.
module testbench;
	import dlle_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 20;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// [1:0] cmd, [11:2] node, [12] side, rest zero
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// [1:0] status, [11:2] new_node, [22:12] left_link, [33:23] right_link,
	// [34] is_removed, rest zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Predicted list state
	logic [LINK_W-1:0] left_of  [NODES];
	logic [LINK_W-1:0] right_of [NODES];
	logic              removed_mark [NODES];
	logic [LINK_W-1:0] next_free;

	result_t pending_res [$];
	result_t seen_res;
	result_t want_res;

	bit no_idle;
	bit hold_req;
	int fails;
	int cmds_sent;
	int res_checked;
	int cycles;
	int status_tally [4];

	doubly_linked_list_engine_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Apply one command to the predicted list, return the result it should give
	function automatic result_t list_apply(input cmd_code_t c, input logic [NODE_W-1:0] n,
			input logic sd);
		result_t           r;
		logic [LINK_W-1:0] anc;
		logic [LINK_W-1:0] nxt;
		logic [LINK_W-1:0] lf;
		logic [LINK_W-1:0] rt;
		logic [NODE_W-1:0] x;
		r = '0;
		if (c == CMD_BAD || LINK_W'(n) >= next_free) begin
			r.status = ST_INVALID;
		end else if (c == CMD_INSERT) begin
			if (next_free >= END_LINK)
				r.status = ST_FULL;
			else if (removed_mark[n])
				r.status = ST_REMOVED;
			else if (!sd && n == '0)
				r.status = ST_INVALID;
			else begin
				// left insert goes after the anchor's left neighbor
				anc = sd ? LINK_W'(n) : left_of[n];
				if (anc >= END_LINK) begin
					r.status = ST_INVALID;
				end else begin
					x   = next_free[NODE_W-1:0];
					nxt = right_of[anc[NODE_W-1:0]];
					right_of[x] = nxt;
					left_of[x]  = anc;
					// no back-link into the end marker
					if (nxt < END_LINK)
						left_of[nxt[NODE_W-1:0]] = LINK_W'(x);
					right_of[anc[NODE_W-1:0]] = LINK_W'(x);
					next_free  = next_free + 1'b1;
					r.status   = ST_OK;
					r.new_node = x;
				end
			end
		end else if (c == CMD_REMOVE) begin
			if (n == '0)
				r.status = ST_INVALID;
			else if (removed_mark[n])
				r.status = ST_REMOVED;
			else begin
				removed_mark[n] = 1'b1;
				lf = left_of[n];
				rt = right_of[n];
				if (lf < END_LINK)
					right_of[lf[NODE_W-1:0]] = rt;
				if (rt < END_LINK)
					left_of[rt[NODE_W-1:0]] = lf;
				r.status = ST_OK;
			end
		end else begin
			r.status     = ST_OK;
			r.left_link  = (n == '0) ? END_LINK : left_of[n];
			r.right_link = right_of[n];
			r.is_removed = removed_mark[n];
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// Any node created so far, live or removed
	function automatic logic [NODE_W-1:0] pick_node();
		return NODE_W'($urandom_range(0, int'(next_free) - 1));
	endfunction

	// Offer one command, with an occasional idle burst first; predict on acceptance
	task automatic send_cmd(input cmd_code_t c, input logic [NODE_W-1:0] n, input logic sd);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = IN_TDATA_W'({sd, n, c});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_res.push_back(list_apply(c, n, sd));
		cmds_sent++;
	endtask

	// Mostly well-formed commands on existing nodes, some noise over the whole field range
	task automatic random_cmd(input int noise_pct);
		cmd_code_t         c;
		logic [NODE_W-1:0] n;
		logic              sd;
		int                roll;
		sd   = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < noise_pct) begin
			c = cmd_code_t'($urandom_range(0, 3));
			n = NODE_W'($urandom_range(0, NODES - 1));
		end else begin
			roll = $urandom_range(0, 99);
			c = (roll < 45) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE : CMD_QUERY;
			n = pick_node();
		end
		send_cmd(c, n, sd);
	endtask

	// Head, tail, left and right inserts, removes, and the invalid and already-removed rejections
	task automatic test_directed();
		send_cmd(CMD_QUERY, 0, 0);
		send_cmd(CMD_QUERY, 1, 0);
		send_cmd(CMD_QUERY, 2, 1);
		send_cmd(CMD_INSERT, 0, 0);
		send_cmd(CMD_INSERT, 1, 1);
		send_cmd(CMD_INSERT, 0, 1);
		send_cmd(CMD_INSERT, 1, 0);
		send_cmd(CMD_INSERT, 3, 0);
		send_cmd(CMD_BAD, 1, 1);
		send_cmd(CMD_BAD, NODE_W'(NODES - 1), 0);
		send_cmd(CMD_REMOVE, 0, 0);
		send_cmd(CMD_REMOVE, 2, 0);
		send_cmd(CMD_REMOVE, 2, 1);
		send_cmd(CMD_INSERT, 2, 1);
		send_cmd(CMD_INSERT, 2, 0);
		send_cmd(CMD_QUERY, 2, 0);
		send_cmd(CMD_QUERY, 1, 1);
		send_cmd(CMD_REMOVE, 5, 0);
		send_cmd(CMD_QUERY, 0, 1);
		send_cmd(CMD_REMOVE, NODE_W'(NODES - 1), 1);
		send_cmd(CMD_INSERT, NODE_W'(NODES - 1), 1);
		send_cmd(CMD_QUERY, NODE_W'(NODES - 1), 1);
		send_cmd(CMD_INSERT, 1, 1);
		send_cmd(CMD_QUERY, 6, 0);
		send_cmd(CMD_QUERY, 3, 0);
	endtask

	task automatic test_random_mix();
		repeat (300) random_cmd(15);
	endtask

	// Output held off for a long stretch while commands keep coming
	task automatic test_output_stall();
		hold_req = 1'b1;
		repeat (40) random_cmd(10);
	endtask

	// Back-to-back commands, no idling on either side
	task automatic test_full_steady();
		no_idle = 1'b1;
		send_cmd(CMD_INSERT, 0, 1);
		send_cmd(CMD_QUERY, NODE_W'(NODES - 1), 0);
		send_cmd(CMD_REMOVE, NODE_W'(NODES - 1), 0);
		send_cmd(CMD_QUERY, NODE_W'(NODES - 1), 1);
		send_cmd(CMD_INSERT, NODE_W'(NODES - 1), 0);
		repeat (80) random_cmd(10);
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res = result_t'(m_tdata[RES_W-1:0]);
			status_tally[seen_res.status]++;
			if (pending_res.size() == 0) begin
				$error("result transfer with no command outstanding");
				fails++;
			end else begin
				want_res = pending_res.pop_front();
				check_field("status", want_res.status, seen_res.status);
				check_field("new_node", want_res.new_node, seen_res.new_node);
				check_field("left_link", want_res.left_link, seen_res.left_link);
				check_field("right_link", want_res.right_link, seen_res.right_link);
				check_field("is_removed", want_res.is_removed, seen_res.is_removed);
				res_checked++;
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("doubly_linked_list_engine_unit test failed");
		$finish;
	end

	// Main sequence
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		no_idle  = 1'b0;
		hold_req = 1'b0;
		fails    = 0;
		cmds_sent   = 0;
		res_checked = 0;
		for (int i = 0; i < 4; i++)
			status_tally[i] = 0;
		// list after reset: head -> node 1 -> end
		for (int i = 0; i < NODES; i++) begin
			left_of[i]      = '0;
			right_of[i]     = '0;
			removed_mark[i] = 1'b0;
		end
		right_of[0] = LINK_W'(1);
		right_of[1] = END_LINK;
		next_free   = NEXT_ID_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_mix();
		test_output_stall();
		test_full_steady();

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d commands sent, %0d results checked, next free id %0d",
			cmds_sent, res_checked, next_free);
		$display("status counts: ok %0d, already removed %0d, invalid %0d, full %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
		if (fails == 0)
			$display("doubly_linked_list_engine_unit test passed");
		else
			$display("doubly_linked_list_engine_unit test failed");
		$finish;
	end

endmodule
